// ----- rtl/hpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants for the hashed page table mmu
// field widths, command and status codes, register indexes
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_INSERT    = 2'd1,
    CMD_WRITE_SR  = 2'd2,
    CMD_WRITE_BAT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_PASS     = 3'd0,
    ST_DSTORE   = 3'd1,
    ST_BAT_HIT  = 3'd2,
    ST_PAGE_HIT = 3'd3,
    ST_MISS     = 3'd4,
    ST_INSERTED = 3'd5,
    ST_FULL     = 3'd6,
    ST_REG_WR   = 3'd7
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_HTAB_MASK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ITRANS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DTRANS    = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] vaddr;
    logic        is_instruction;
    logic [31:0] phys_in;
    logic [3:0]  preferred_slot;
    logic [3:0]  reg_index;
    logic [31:0] word_hi;
    logic [31:0] word_lo;
  } req_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_t;

  // page entry: valid, h, vsid[23:0], api[5:0], ppn[19:0]
  typedef struct packed {
    logic        valid;
    logic        hbit;
    logic [23:0] vsid;
    logic [5:0]  api;
    logic [19:0] ppn;
  } pte_t;

endpackage

// ----- rtl/hpt_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_stream_if: valid/ready channel with a generic payload
// one transaction moves at a clock edge with valid and ready high
// ----------------------------------------------------------------------------
interface hpt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/hashed_page_table_mmu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_page_table_mmu_unit: 32-bit hashed page table mmu
// translates addresses, inserts page entries, holds segment and bat regs
// ----------------------------------------------------------------------------
// Channels: req (sink) carries one command per transaction, rsp (source)
// returns exactly one result per command, cfg (sink) writes the table mask
// and the two translate enables; the user writes them only while the unit
// is idle, which the unit itself does not enforce. A sequencer walks the
// work: each bat of the selected side is checked in turn in S_BAT, then
// each of up to sixteen page entries takes one memory read in S_RD and a
// compare of the registered read data in S_CMP.
// One command is in flight at a time; req ready drops while it is worked.
// After reset the page memory is swept clear, with req not ready; cfg writes
// are taken at all times.
// The result sits in an output register until rsp is taken; a stalled
// receiver holds the unit in its done state, and the next command is
// accepted in the same cycle the result is taken.
// ----------------------------------------------------------------------------
module hashed_page_table_mmu_unit #(
  parameter int unsigned GROUP_COUNT = 2048,
  parameter int unsigned BAT_COUNT   = 4
) (
  input logic clk_i,
  input logic rst_ni,
  hpt_stream_if.sink   req,
  hpt_stream_if.source rsp,
  hpt_stream_if.sink   cfg
);
  import hpt_pkg::*;

  localparam int unsigned GrpW  = $clog2(GROUP_COUNT);
  localparam int unsigned AddrW = GrpW + 3;
  localparam int unsigned BatW  = (BAT_COUNT > 1) ? $clog2(BAT_COUNT) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BAT  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  req_t        req_q;
  logic [8:0]  mask_ext_q;
  logic        itrans_q, dtrans_q;
  logic [31:0] sr_q [16];
  logic [63:0] bat_q [2*BAT_COUNT];
  logic [BatW-1:0] bat_idx_q, bat_idx_d;
  logic [2:0]  slot_q, slot_d;
  logic        pass_q, pass_d;
  rsp_t        rsp_q, rsp_d;
  logic        busy;

  logic        mem_en, mem_we;
  logic [AddrW-1:0] mem_addr;
  pte_t        mem_wdata, mem_rdata;

  hpt_pte_mem #(.AddrW(AddrW)) u_mem (
    .clk_i, .rst_ni, .en_i(mem_en), .we_i(mem_we), .addr_i(mem_addr),
    .wdata_i(mem_wdata), .rdata_o(mem_rdata), .busy_o(busy)
  );

  assign cfg.ready   = 1'b1;
  assign req.ready   = !busy && (state_q == S_IDLE || (state_q == S_DONE && rsp.ready));
  assign rsp.valid   = (state_q == S_DONE);
  assign rsp.payload = rsp_q;

  // derived values of the held command
  logic [31:0] sr;
  logic [23:0] vsid;
  logic [27:0] vsid28;
  logic [5:0]  api;
  logic [18:0] hash, mask19;
  logic [GrpW-1:0] grp;
  logic        on;
  logic [63:0] bat;
  logic [31:0] bhi, blo, bblk, bmask;
  logic        bhit;
  pte_t        want;

  always_comb begin
    sr     = sr_q[req_q.vaddr[31:28]];
    vsid28 = sr[27:0];
    vsid   = sr[23:0];
    api    = req_q.vaddr[27:22];
    mask19 = {mask_ext_q, 10'h3ff};
    hash   = (vsid28[18:0] ^ {3'b0, req_q.vaddr[27:12]}) ^ {19{pass_q}};
    grp    = GrpW'(20'(hash & mask19) % 20'(GROUP_COUNT));
    on     = req_q.is_instruction ? itrans_q : dtrans_q;
    bat    = bat_q[(req_q.is_instruction ? BAT_COUNT : 0) + int'(bat_idx_q)];
    bhi    = bat[63:32];
    blo    = bat[31:0];
    bblk   = {9'b0, blo[5:0], 17'b0};
    bmask  = 32'hfffe0000 & ~bblk;
    bhit   = blo[6] && ((req_q.vaddr & bmask) == (bhi & bmask));
    want   = '{valid: 1'b1, hbit: pass_q, vsid: vsid, api: api, ppn: 20'b0};
  end

  always_comb begin
    state_d   = state_q;
    bat_idx_d = bat_idx_q;
    slot_d    = slot_q;
    pass_d    = pass_q;
    rsp_d     = rsp_q;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = {grp, slot_q};
    mem_wdata = '{valid: 1'b1, hbit: 1'b0, vsid: vsid, api: api,
                  ppn: req_q.phys_in[31:12]};
    case (state_q)
      S_IDLE, S_DONE: begin
        if (state_q == S_DONE && rsp.ready) begin
          state_d = S_IDLE;
        end
        if (req.valid && req.ready) begin
          state_d = S_BAT;
        end
      end
      S_BAT: begin
        rsp_d.result_addr = '0;
        if (req_q.cmd == CMD_WRITE_SR || req_q.cmd == CMD_WRITE_BAT) begin
          rsp_d.status = ST_REG_WR;
          state_d      = S_DONE;
        end else if (req_q.cmd == CMD_INSERT) begin
          state_d = S_RD;
        end else if (!on) begin
          rsp_d = '{result_addr: req_q.vaddr, status: ST_PASS};
          state_d = S_DONE;
        end else if (sr[31]) begin
          rsp_d = '{result_addr: {vsid28[3:0], req_q.vaddr[27:0]}, status: ST_DSTORE};
          state_d = S_DONE;
        end else if (bhit) begin
          rsp_d.result_addr = (blo & 32'hfffe0000 & bmask) |
                              (req_q.vaddr & (bblk | 32'h0001ffff));
          rsp_d.status = ST_BAT_HIT;
          state_d = S_DONE;
        end else if (int'(bat_idx_q) == BAT_COUNT - 1) begin
          state_d = S_RD;
        end else begin
          bat_idx_d = bat_idx_q + 1'b1;
        end
      end
      S_RD: begin
        mem_en  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (req_q.cmd == CMD_INSERT) begin
          if (!mem_rdata.valid || {1'b0, slot_q} == req_q.preferred_slot) begin
            mem_en  = 1'b1;
            mem_we  = 1'b1;
            rsp_d.status = ST_INSERTED;
            state_d = S_DONE;
          end else if (slot_q == 3'd7) begin
            rsp_d.status = ST_FULL;
            state_d = S_DONE;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_RD;
          end
        end else if ({mem_rdata.valid, mem_rdata.hbit, mem_rdata.vsid, mem_rdata.api}
                     == {want.valid, want.hbit, want.vsid, want.api}) begin
          rsp_d = '{result_addr: {mem_rdata.ppn, req_q.vaddr[11:0]}, status: ST_PAGE_HIT};
          state_d = S_DONE;
        end else if (slot_q == 3'd7) begin
          slot_d = '0;
          if (pass_q) begin
            rsp_d.status = ST_MISS;
            state_d = S_DONE;
          end else begin
            pass_d  = 1'b1;
            state_d = S_RD;
          end
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (req.valid && req.ready) begin
      bat_idx_d = '0;
      slot_d    = '0;
      pass_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mask_ext_q <= '0;
      itrans_q   <= 1'b0;
      dtrans_q   <= 1'b0;
      for (int i = 0; i < 16; i++) sr_q[i] <= '0;
      for (int i = 0; i < 2*BAT_COUNT; i++) bat_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid) begin
        case (cfg.payload.index)
          CFG_HTAB_MASK: mask_ext_q <= cfg.payload.data[8:0];
          CFG_ITRANS:    itrans_q   <= cfg.payload.data[0];
          CFG_DTRANS:    dtrans_q   <= cfg.payload.data[0];
          default: ;
        endcase
      end
      if (state_q == S_BAT && req_q.cmd == CMD_WRITE_SR) begin
        sr_q[req_q.reg_index] <= req_q.word_hi;
      end
      if (state_q == S_BAT && req_q.cmd == CMD_WRITE_BAT &&
          32'(req_q.reg_index) < BAT_COUNT) begin
        bat_q[(req_q.is_instruction ? BAT_COUNT : 0) + int'(req_q.reg_index)] <=
          {req_q.word_hi, req_q.word_lo};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q <= req.payload;
    end
    bat_idx_q <= bat_idx_d;
    slot_q    <= slot_d;
    pass_q    <= pass_d;
    rsp_q     <= rsp_d;
  end
endmodule

// ----- rtl/hpt_pte_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pte_mem: page entry memory with a clearing sweep after reset
// one port, one read or write a cycle once the clearing sweep is done, registered read data
// ----------------------------------------------------------------------------
module hpt_pte_mem #(
  parameter int unsigned AddrW = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       addr_i,
  input  hpt_pkg::pte_t          wdata_i,
  output hpt_pkg::pte_t          rdata_o,
  output logic                   busy_o
);
  import hpt_pkg::*;

  pte_t             mem_q [2**AddrW];
  logic [AddrW:0]   clr_q;
  logic [AddrW:0]   clr_d;

  assign busy_o = ~clr_q[AddrW];
  assign clr_d  = busy_o ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem_q[clr_q[AddrW-1:0]] <= '0;
    end else if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

// ----- test/tb_hashed_page_table_mmu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_page_table_mmu_unit: self-checking bench for the hashed page mmu
// drives segment, bat, insert and translate commands with random gaps and
// stalls, predicts every result and compares it field by field in order
// ----------------------------------------------------------------------------
module tb_hashed_page_table_mmu_unit;
  import hpt_pkg::*;

  localparam int unsigned GroupCnt = 2048;
  localparam int unsigned BatCnt   = 4;
  localparam longint      CycleLimit = 1500000;

  class mmu_scoreboard;
    logic [8:0]  mask_ext;
    logic        itrans_on;
    logic        dtrans_on;
    logic [31:0] seg_reg [16];
    logic [63:0] bat_pair [2*BatCnt];
    pte_t        pte_mem [GroupCnt*8];
    rsp_t        pending [$];
    int          n_bad;

    function void clear();
      mask_ext = '0;
      itrans_on = 1'b0;
      dtrans_on = 1'b0;
      foreach (seg_reg[i]) seg_reg[i] = '0;
      foreach (bat_pair[i]) bat_pair[i] = '0;
      foreach (pte_mem[i]) pte_mem[i] = '0;
      pending.delete();
      n_bad = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_HTAB_MASK: mask_ext = val[8:0];
        CFG_ITRANS:    itrans_on = val[0];
        CFG_DTRANS:    dtrans_on = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned group_of(logic [18:0] hash);
      logic [18:0] m;
      m = {mask_ext, 10'h3ff};
      return ((hash & m) % GroupCnt) * 8;
    endfunction

    function rsp_t translate(req_t r);
      rsp_t        o;
      logic [31:0] sr, hi, lo, blk, bm;
      logic [23:0] vsid;
      logic [18:0] hash;
      int unsigned base;
      pte_t        e;
      o = '0;
      if (!(r.is_instruction ? itrans_on : dtrans_on)) begin
        o.result_addr = r.vaddr;
        o.status = ST_PASS;
        return o;
      end
      sr = seg_reg[r.vaddr[31:28]];
      if (sr[31]) begin
        o.result_addr = {sr[3:0], r.vaddr[27:0]};
        o.status = ST_DSTORE;
        return o;
      end
      for (int i = 0; i < BatCnt; i++) begin
        {hi, lo} = bat_pair[(r.is_instruction ? BatCnt : 0) + i];
        blk = {9'd0, lo[5:0], 17'd0};
        bm = 32'hfffe0000 & ~blk;
        if (lo[6] && ((r.vaddr & bm) == (hi & bm))) begin
          o.result_addr = (lo & bm) | (r.vaddr & (blk | 32'h1ffff));
          o.status = ST_BAT_HIT;
          return o;
        end
      end
      vsid = sr[23:0];
      hash = sr[18:0] ^ {3'd0, r.vaddr[27:12]};
      for (int p = 0; p < 2; p++) begin
        base = group_of(hash);
        for (int i = 0; i < 8; i++) begin
          e = pte_mem[base + i];
          if (e.valid && e.hbit == p[0] && e.vsid == vsid && e.api == r.vaddr[27:22]) begin
            o.result_addr = {e.ppn, r.vaddr[11:0]};
            o.status = ST_PAGE_HIT;
            return o;
          end
        end
        hash = hash ^ 19'h7ffff;
      end
      o.status = ST_MISS;
      return o;
    endfunction

    function void note_request(req_t r);
      rsp_t        o;
      logic [31:0] sr;
      int unsigned base;
      o = '0;
      case (cmd_e'(r.cmd))
        CMD_TRANSLATE: o = translate(r);
        CMD_INSERT: begin
          sr = seg_reg[r.vaddr[31:28]];
          base = group_of(sr[18:0] ^ {3'd0, r.vaddr[27:12]});
          o.status = ST_FULL;
          for (int i = 0; i < 8; i++) begin
            if (r.preferred_slot == i || !pte_mem[base + i].valid) begin
              pte_mem[base + i] = {1'b1, 1'b0, sr[23:0], r.vaddr[27:22], r.phys_in[31:12]};
              o.status = ST_INSERTED;
              break;
            end
          end
        end
        CMD_WRITE_SR: begin
          seg_reg[r.reg_index] = r.word_hi;
          o.status = ST_REG_WR;
        end
        default: begin
          if (r.reg_index < BatCnt)
            bat_pair[(r.is_instruction ? BatCnt : 0) + r.reg_index] = {r.word_hi, r.word_lo};
          o.status = ST_REG_WR;
        end
      endcase
      pending.push_back(o);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result addr=%h status=%0d",
                                  got.result_addr, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.result_addr !== want.result_addr || got.status !== want.status) begin
        n_bad++;
        if (n_bad <= 10)
          $display("result differs: expected addr=%h status=%0d, got addr=%h status=%0d",
                   want.result_addr, want.status, got.result_addr, got.status);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  longint cycles;
  mmu_scoreboard sb;

  hpt_stream_if #(.payload_t(req_t)) req_if ();
  hpt_stream_if #(.payload_t(rsp_t)) rsp_if ();
  hpt_stream_if #(.payload_t(cfg_t)) cfg_if ();

  hashed_page_table_mmu_unit #(
    .GROUP_COUNT(GroupCnt),
    .BAT_COUNT  (BatCnt)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_if.sink),
    .rsp   (rsp_if.source),
    .cfg   (cfg_if.sink)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("hashed_page_table_mmu_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver with random stalls, checks every result transaction
  initial begin
    int unsigned wait_n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_n != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_result(rsp_if.payload);
    end
  end

  // valid stays up after a transaction until the next gap or a drain
  task automatic send_cmd(req_t r);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.payload <= r;
    req_if.valid <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_if.payload <= '{index: idx, data: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic req_t rand_req();
    req_t r;
    r = '{cmd: 2'($urandom), vaddr: $urandom, is_instruction: 1'($urandom),
          phys_in: $urandom, preferred_slot: 4'($urandom_range(0, 15)),
          reg_index: 4'($urandom), word_hi: $urandom, word_lo: $urandom};
    return r;
  endfunction

  // small pool of segments and pages so inserts and lookups meet
  function automatic req_t shaped_req();
    req_t r;
    int unsigned k;
    r = rand_req();
    k = $urandom_range(0, 99);
    r.vaddr[31:28] = 4'($urandom_range(0, 3));
    r.vaddr[27:12] = {2'($urandom_range(0, 3)), 12'h0, 2'($urandom_range(0, 3))};
    if (k < 45) r.cmd = CMD_TRANSLATE;
    else if (k < 75) begin
      r.cmd = CMD_INSERT;
      r.preferred_slot = 4'($urandom_range(0, 8));
    end else if (k < 85) begin
      r.cmd = CMD_WRITE_SR;
      r.reg_index = 4'($urandom_range(0, 3));
      r.word_hi[31] = ($urandom_range(0, 7) == 0);
      r.word_hi[30:4] = $urandom_range(0, 1) ? 27'h0 : r.word_hi[30:4];
    end else if (k < 95) begin
      r.cmd = CMD_WRITE_BAT;
      r.reg_index = 4'($urandom_range(0, 5));
    end
    return r;
  endfunction

  initial begin
    req_t r;
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // passthrough with translation off, extremes of the fields
    r = '0;
    r.cmd = CMD_TRANSLATE;
    send_cmd(r);
    r.vaddr = '1; r.is_instruction = 1'b1; r.phys_in = '1; r.word_hi = '1; r.word_lo = '1;
    send_cmd(r);
    drain();
    write_cfg(CFG_ITRANS, 32'd1);
    write_cfg(CFG_DTRANS, 32'hffffffff);
    write_cfg(CFG_HTAB_MASK, 32'h1ff);
    // direct store segment, bat hit with block mask, out-of-range bat
    r = '0; r.cmd = CMD_WRITE_SR; r.reg_index = 4'hf; r.word_hi = 32'hffffffff;
    send_cmd(r);
    r = '0; r.vaddr = 32'hf123_4567; send_cmd(r);
    r = '0; r.cmd = CMD_WRITE_BAT; r.reg_index = 4'd0;
    r.word_hi = 32'h1000_0000; r.word_lo = 32'h8000_007f;
    send_cmd(r);
    r.reg_index = 4'hf; r.is_instruction = 1'b1; send_cmd(r);
    r = '0; r.vaddr = 32'h107f_ffff; send_cmd(r);
    r.is_instruction = 1'b1; send_cmd(r);
    // ten inserts spread over two groups, one with a preferred slot, then lookups
    for (int i = 0; i < 10; i++) begin
      r = '0; r.cmd = CMD_INSERT; r.vaddr = 32'h0000_5000 | (i << 22);
      r.phys_in = 32'hfffff000 - i; r.preferred_slot = (i == 9) ? 4'd7 : 4'd8;
      send_cmd(r);
    end
    r = '0; r.vaddr = 32'h0240_5abc; send_cmd(r);
    r.vaddr = 32'h0000_6000; send_cmd(r);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_HTAB_MASK, (ph == 0) ? 32'd0 : (ph == 1) ? 32'h1ff : $urandom);
      write_cfg(CFG_ITRANS, 32'(ph != 2));
      write_cfg(CFG_DTRANS, 32'(ph != 3));
      for (int n = 0; n < 150; n++) send_cmd(($urandom_range(0, 9) == 0) ? rand_req()
                                                                             : shaped_req());
      drain();
    end
    repeat (40) @(posedge clk_i);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("hashed_page_table_mmu_unit: match");
    end else begin
      $display("hashed_page_table_mmu_unit: mismatch");
    end
    $finish;
  end

endmodule
